@@ hdl/fsc_pkg.sv @@
package fsc_pkg;

  // Default number of fraction bits carried by the temperature average.
  localparam int AvgFracBitsDef = 16;

  // Field widths.
  localparam int TempW    = 13;
  localparam int WeightW  = 16;
  localparam int ThrW     = 11;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Throttle limits and the update hysteresis, in 1/16 percent.
  localparam int ThrMax   = 1600;
  localparam int HystStep = 16;

  // Average after reset: 25 degrees in 1/16 degree units.
  localparam int AvgResetTemp = 400;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_FULL_SPEED_TEMP = 3'd0,
    REG_RAMP_START_TEMP = 3'd1,
    REG_FAN_START_TEMP  = 3'd2,
    REG_FAN_STOP_TEMP   = 3'd3,
    REG_RISE_WEIGHT     = 3'd4,
    REG_FALL_WEIGHT     = 3'd5,
    REG_RAMP_GAIN       = 3'd6,
    REG_KICK_LEVEL      = 3'd7
  } cfg_reg_e;

  // Fan operating modes.
  typedef enum logic [1:0] {
    MODE_LOW  = 2'd0,
    MODE_KICK = 2'd1,
    MODE_RAMP = 2'd2,
    MODE_FULL = 2'd3
  } fan_mode_e;

  // Datapath commands issued by the sequencer, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_DIFF    = 4'd1,
    OP_AVG_LO  = 4'd2,
    OP_AVG_HI  = 4'd3,
    OP_AVG_UPD = 4'd4,
    OP_MODE    = 4'd5,
    OP_RAMP_LO = 4'd6,
    OP_RAMP_HI = 4'd7,
    OP_RESULT  = 4'd8
  } dp_op_e;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [TempW-1:0] full_speed_temp;
    logic signed [TempW-1:0] ramp_start_temp;
    logic signed [TempW-1:0] fan_start_temp;
    logic signed [TempW-1:0] fan_stop_temp;
    logic [WeightW-1:0]      rise_weight;
    logic [WeightW-1:0]      fall_weight;
    logic [WeightW-1:0]      ramp_gain;
    logic [ThrW-1:0]         kick_level;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    full_speed_temp: 13'sd1264,
    ramp_start_temp: 13'sd1168,
    fan_start_temp:  13'sd1120,
    fan_stop_temp:   13'sd1104,
    rise_weight:     16'd6554,
    fall_weight:     16'd655,
    ramp_gain:       16'd2560,
    kick_level:      11'd320
  };

endpackage

@@ hdl/fsc_ifs.sv @@
// Sample channel: one temperature reading per transfer.
interface fsc_in_if;
  import fsc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temp_sample;

  modport source (output valid, output temp_sample, input ready);
  modport sink   (input valid, input temp_sample, output ready);
endinterface

// Result channel: held throttle, update flag and fan mode per transfer.
interface fsc_out_if;
  import fsc_pkg::*;
  logic            valid;
  logic            ready;
  logic [ThrW-1:0] throttle;
  logic            throttle_changed;
  logic [1:0]      fan_mode;

  modport source (output valid, output throttle, output throttle_changed, output fan_mode,
                  input ready);
  modport sink   (input valid, input throttle, input throttle_changed, input fan_mode,
                  output ready);
endinterface

@@ hdl/fan_speed_hysteresis_controller.sv @@
// Channel  | Direction | Payload                                  | Transfer
// in_ch    | sink      | temp_sample                              | valid && ready
// out_ch   | source    | throttle, throttle_changed, fan_mode     | valid && ready
// cfg      | write     | cfg_idx_i, cfg_wdata_i                   | cfg_we_i
//
// An item takes the transfer cycle, then seven sequencer steps on one shared
// multiplier (two for the average, two for the ramp) and the average update,
// compare and result steps. A new sample is taken only after the result step
// of the last one, once the sequencer is back in idle.
// A finished result waits in the output register while the next sample is taken;
// the sequencer stalls only if a second result is ready before the first leaves.
// Reset restores the configuration defaults, the 25 degree average and low mode.
module fan_speed_hysteresis_controller #(
  parameter int AVG_FRAC_BITS = fsc_pkg::AvgFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fsc_in_if.sink                        in_ch,
  fsc_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [fsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fsc_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import fsc_pkg::*;

  cfg_t   cfg;
  dp_op_e op;

  // Configuration registers.
  fsc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer and handshakes.
  fsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .out_ready_i (out_ch.ready),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .op_o        (op)
  );

  // Averaging, mode and throttle datapath.
  fsc_dp #(
    .AVG_FRAC_BITS (AVG_FRAC_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (op),
    .cfg_i              (cfg),
    .temp_sample_i      (in_ch.temp_sample),
    .throttle_o         (out_ch.throttle),
    .throttle_changed_o (out_ch.throttle_changed),
    .fan_mode_o         (out_ch.fan_mode)
  );

  // Only one sample is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("sample taken while another is in work");

  // The held throttle never leaves its range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.throttle <= ThrW'(ThrMax)))
    else $error("throttle above full scale");

  // An update in full mode drives the fan to full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.throttle_changed && out_ch.fan_mode == MODE_FULL)
      |-> (out_ch.throttle == ThrW'(ThrMax)))
    else $error("full mode update without full throttle");

  // An update in low mode stops the fan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.throttle_changed && out_ch.fan_mode == MODE_LOW)
      |-> (out_ch.throttle == '0))
    else $error("low mode update without zero throttle");

endmodule

@@ hdl/fsc_regs.sv @@
module fsc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fsc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fsc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output fsc_pkg::cfg_t                 cfg_o
);
  import fsc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Write decode: each register keeps the low bits of the write data.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FULL_SPEED_TEMP: cfg_d.full_speed_temp = $signed(cfg_wdata_i[TempW-1:0]);
        REG_RAMP_START_TEMP: cfg_d.ramp_start_temp = $signed(cfg_wdata_i[TempW-1:0]);
        REG_FAN_START_TEMP:  cfg_d.fan_start_temp  = $signed(cfg_wdata_i[TempW-1:0]);
        REG_FAN_STOP_TEMP:   cfg_d.fan_stop_temp   = $signed(cfg_wdata_i[TempW-1:0]);
        REG_RISE_WEIGHT:     cfg_d.rise_weight     = cfg_wdata_i[WeightW-1:0];
        REG_FALL_WEIGHT:     cfg_d.fall_weight     = cfg_wdata_i[WeightW-1:0];
        REG_RAMP_GAIN:       cfg_d.ramp_gain       = cfg_wdata_i[WeightW-1:0];
        REG_KICK_LEVEL:      cfg_d.kick_level      = cfg_wdata_i[ThrW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/fsc_ctrl.sv @@
module fsc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_ready_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output fsc_pkg::dp_op_e  op_o
);
  import fsc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_AVG_LO   = 8'b0000_0010,
    S_AVG_HI   = 8'b0000_0100,
    S_AVG_UPD  = 8'b0000_1000,
    S_MODE     = 8'b0001_0000,
    S_RAMP_LO  = 8'b0010_0000,
    S_RAMP_HI  = 8'b0100_0000,
    S_RESULT   = 8'b1000_0000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The output register can take a new result when empty or being emptied.
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer: one datapath command per state.
  always_comb begin
    state_d     = state_q;
    op_o        = OP_NONE;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_DIFF;
          state_d = S_AVG_LO;
        end
      end
      S_AVG_LO: begin
        op_o    = OP_AVG_LO;
        state_d = S_AVG_HI;
      end
      S_AVG_HI: begin
        op_o    = OP_AVG_HI;
        state_d = S_AVG_UPD;
      end
      S_AVG_UPD: begin
        op_o    = OP_AVG_UPD;
        state_d = S_MODE;
      end
      S_MODE: begin
        op_o    = OP_MODE;
        state_d = S_RAMP_LO;
      end
      S_RAMP_LO: begin
        op_o    = OP_RAMP_LO;
        state_d = S_RAMP_HI;
      end
      S_RAMP_HI: begin
        op_o    = OP_RAMP_HI;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        // Wait here while the previous result has not been transferred.
        if (out_free) begin
          op_o        = OP_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/fsc_dp.sv @@
module fsc_dp #(
  parameter int AVG_FRAC_BITS = fsc_pkg::AvgFracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fsc_pkg::dp_op_e                op_i,
  input  fsc_pkg::cfg_t                  cfg_i,
  input  logic signed [fsc_pkg::TempW-1:0] temp_sample_i,
  output logic [fsc_pkg::ThrW-1:0]       throttle_o,
  output logic                           throttle_changed_o,
  output logic [1:0]                     fan_mode_o
);
  import fsc_pkg::*;

  // Average width, difference width, shared multiplier widths.
  localparam int AW   = TempW + AVG_FRAC_BITS;
  localparam int DW   = AW + 1;
  localparam int HiW  = DW - 16;
  localparam int MulW = (HiW > 17) ? HiW : 17;
  localparam int PW   = MulW + WeightW + 1;
  localparam int AccW = PW + 16;
  localparam int RampShift = 8 + AVG_FRAC_BITS;
  localparam logic signed [AW-1:0] AvgReset =
    {TempW'(AvgResetTemp), {AVG_FRAC_BITS{1'b0}}};

  // State carried between items.
  logic signed [AW-1:0]   avg_q;
  fan_mode_e              mode_q;
  logic [ThrW-1:0]        held_q;

  // Working registers of one item.
  logic signed [DW-1:0]   d_q;
  logic [WeightW-1:0]     w_q;
  logic signed [PW-1:0]   p_q;
  logic signed [AccW-1:0] acc_q;

  // Result register.
  logic [ThrW-1:0]        out_thr_q;
  logic                   out_chg_q;
  logic [1:0]             out_mode_q;

  // Scaled sample and thresholds.
  logic signed [AW-1:0]   sample_s, full_s, rstart_s, fstart_s, stop_s;
  logic signed [DW-1:0]   diff_in, ramp_diff;

  assign sample_s = {temp_sample_i, {AVG_FRAC_BITS{1'b0}}};
  assign full_s   = {cfg_i.full_speed_temp, {AVG_FRAC_BITS{1'b0}}};
  assign rstart_s = {cfg_i.ramp_start_temp, {AVG_FRAC_BITS{1'b0}}};
  assign fstart_s = {cfg_i.fan_start_temp, {AVG_FRAC_BITS{1'b0}}};
  assign stop_s   = {cfg_i.fan_stop_temp, {AVG_FRAC_BITS{1'b0}}};

  assign diff_in   = DW'(sample_s) - DW'(avg_q);
  assign ramp_diff = DW'(avg_q) - DW'(stop_s);

  // Shared multiplier: low half of the difference unsigned, high half signed.
  logic signed [HiW-1:0]  d_hi;
  logic signed [MulW-1:0] mul_a;
  logic [WeightW-1:0]     mul_b;
  logic signed [PW-1:0]   mul_p;
  logic                   use_hi;

  assign d_hi   = d_q[DW-1:16];
  assign use_hi = (op_i == OP_AVG_HI) || (op_i == OP_RAMP_HI);
  assign mul_a  = use_hi ? MulW'(d_hi) : $signed(MulW'(d_q[15:0]));
  assign mul_b  = ((op_i == OP_RAMP_LO) || (op_i == OP_RAMP_HI)) ? cfg_i.ramp_gain : w_q;
  assign mul_p  = mul_a * $signed({1'b0, mul_b});

  // New mode from the updated average and the previous mode.
  fan_mode_e mode_next;
  always_comb begin
    if (avg_q >= full_s) begin
      mode_next = MODE_FULL;
    end else if (avg_q >= rstart_s) begin
      mode_next = MODE_RAMP;
    end else if (avg_q >= fstart_s) begin
      mode_next = MODE_KICK;
    end else if ((mode_q == MODE_KICK || mode_q == MODE_RAMP) && avg_q >= stop_s) begin
      mode_next = MODE_KICK;
    end else begin
      mode_next = MODE_LOW;
    end
  end

  // Candidate throttle for the current mode, saturated to the throttle range.
  logic signed [AccW-1:0] ramp_val;
  logic [ThrW-1:0]        cand;
  logic signed [ThrW:0]   step;
  logic                   changed;

  assign ramp_val = acc_q >>> RampShift;

  always_comb begin
    case (mode_q)
      MODE_FULL: cand = ThrW'(ThrMax);
      MODE_RAMP: begin
        if (acc_q < 0) begin
          cand = '0;
        end else if (ramp_val > AccW'(ThrMax)) begin
          cand = ThrW'(ThrMax);
        end else begin
          cand = ramp_val[ThrW-1:0];
        end
      end
      MODE_KICK: cand = (cfg_i.kick_level > ThrW'(ThrMax)) ? ThrW'(ThrMax) : cfg_i.kick_level;
      default:   cand = '0;
    endcase
  end

  // Update the held throttle only on a move of more than one percent.
  assign step    = $signed({1'b0, cand}) - $signed({1'b0, held_q});
  assign changed = (step > (ThrW+1)'(HystStep)) || (step < -(ThrW+1)'(HystStep));

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q  <= AvgReset;
      mode_q <= MODE_LOW;
      held_q <= '0;
    end else begin
      if (op_i == OP_AVG_UPD) begin
        avg_q <= avg_q + acc_q[AW-1:0];
      end
      if (op_i == OP_MODE) begin
        mode_q <= mode_next;
      end
      if (op_i == OP_RESULT && changed) begin
        held_q <= cand;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_DIFF: begin
        d_q <= diff_in;
        w_q <= (diff_in > 0) ? cfg_i.rise_weight : cfg_i.fall_weight;
      end
      OP_AVG_LO, OP_RAMP_LO: begin
        p_q <= mul_p;
      end
      OP_AVG_HI: begin
        acc_q <= AccW'(mul_p) + AccW'(p_q >>> 16);
      end
      OP_MODE: begin
        d_q <= ramp_diff;
      end
      OP_RAMP_HI: begin
        acc_q <= (AccW'(mul_p) <<< 16) + AccW'(p_q);
      end
      OP_RESULT: begin
        out_thr_q  <= changed ? cand : held_q;
        out_chg_q  <= changed;
        out_mode_q <= mode_q;
      end
      default: begin
      end
    endcase
  end

  assign throttle_o         = out_thr_q;
  assign throttle_changed_o = out_chg_q;
  assign fan_mode_o         = out_mode_q;

endmodule
